/* rtl/core/ffha_pkg.sv */
package ffha_pkg;

    localparam int HEAP_GRANULES = 4096;
    localparam int IDX_W = $clog2(HEAP_GRANULES);
    localparam int GRAN_W = IDX_W + 1;
    localparam logic [GRAN_W-1:0] NONE_MARK = GRAN_W'(HEAP_GRANULES);
    localparam logic [GRAN_W-1:0] MIN_GRANULES = GRAN_W'(2);

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ALLOC_FAIL = 2'd1;
    localparam logic [1:0] ST_FREE_BAD = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE = 1'b1;

    // Sequencer steps; the datapath acts on the step it is told.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] S_CLEAR = 5'd0;
    localparam logic [STEP_W-1:0] S_IDLE = 5'd1;
    localparam logic [STEP_W-1:0] S_DISP = 5'd2;
    localparam logic [STEP_W-1:0] S_WALK = 5'd3;
    localparam logic [STEP_W-1:0] S_WALK_W = 5'd4;
    localparam logic [STEP_W-1:0] S_TOP = 5'd5;
    localparam logic [STEP_W-1:0] S_RM_RD = 5'd6;
    localparam logic [STEP_W-1:0] S_RM_WR = 5'd7;
    localparam logic [STEP_W-1:0] S_SPLIT = 5'd8;
    localparam logic [STEP_W-1:0] S_SPL2 = 5'd9;
    localparam logic [STEP_W-1:0] S_F_HD = 5'd10;
    localparam logic [STEP_W-1:0] S_MG_RD = 5'd11;
    localparam logic [STEP_W-1:0] S_MG_P = 5'd12;
    localparam logic [STEP_W-1:0] S_MG_PW = 5'd13;
    localparam logic [STEP_W-1:0] S_MG_SUM = 5'd14;
    localparam logic [STEP_W-1:0] S_MG_SET = 5'd15;
    localparam logic [STEP_W-1:0] S_PS1 = 5'd16;
    localparam logic [STEP_W-1:0] S_PS2 = 5'd17;
    localparam logic [STEP_W-1:0] S_DONE = 5'd18;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_bytes;
        logic [15:0] free_address;
    } t_in_item;

    typedef struct packed {
        logic [15:0] address;
        logic [1:0]  status;
        logic [12:0] merged_granules;
    } t_out_item;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              load;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic req_zero;
        logic free_bad;
        logic cur_none;
        logic fit;
        logic split;
        logic hdr_inuse;
        logic nfree;
        logic pfree;
        logic clr_last;
    } t_dp_stat;

endpackage

/* rtl/core/ffha_ctrl.sv */
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy,
    output logic     o_done
);

    logic [STEP_W-1:0] r_state, n_state;
    logic [STEP_W-1:0] r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ret <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_DISP;
            end
            S_DISP: begin
                if (i_stat.kind == KIND_ALLOC) begin
                    n_state = i_stat.req_zero ? S_DONE : S_WALK;
                end else begin
                    n_state = i_stat.free_bad ? S_DONE : S_F_HD;
                end
            end
            S_WALK: begin
                n_state = i_stat.cur_none ? S_TOP : S_WALK_W;
            end
            S_WALK_W: begin
                if (i_stat.fit) begin
                    n_state = S_RM_RD;
                    n_ret = S_SPLIT;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_TOP: n_state = S_DONE;
            S_RM_RD: n_state = S_RM_WR;
            S_RM_WR: n_state = r_ret;
            S_SPLIT: begin
                n_state = i_stat.split ? S_SPL2 : S_DONE;
            end
            S_SPL2: n_state = S_MG_RD;
            S_F_HD: begin
                n_state = i_stat.hdr_inuse ? S_MG_RD : S_DONE;
            end
            S_MG_RD: n_state = S_MG_P;
            S_MG_P: n_state = S_MG_PW;
            S_MG_PW: begin
                if (i_stat.nfree) begin
                    n_state = S_RM_RD;
                    n_ret = S_MG_SUM;
                end else begin
                    n_state = S_MG_SUM;
                end
            end
            S_MG_SUM: begin
                if (i_stat.pfree) begin
                    n_state = S_RM_RD;
                    n_ret = S_MG_SET;
                end else begin
                    n_state = S_MG_SET;
                end
            end
            S_MG_SET: n_state = S_PS1;
            S_PS1: n_state = S_PS2;
            S_PS2: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.step = r_state;
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

/* rtl/core/ffha_dp.sv */
module ffha_dp
    import ffha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_item,
    output t_dp_stat  o_stat,
    output t_out_item o_result
);

    logic [13:0] r_hdr_mem [HEAP_GRANULES];
    logic [GRAN_W-1:0] r_ftr_mem [HEAP_GRANULES];
    logic [GRAN_W-1:0] r_nxt_mem [HEAP_GRANULES];
    logic [GRAN_W-1:0] r_prv_mem [HEAP_GRANULES];

    logic [13:0] r_hdr_q;
    logic [GRAN_W-1:0] r_ftr_q, r_nxt_q, r_prv_q;

    logic              hdr_we, hdr_re, ftr_we, ftr_re, nxt_we, nxt_re, prv_we, prv_re;
    logic [IDX_W-1:0]  hdr_wa, hdr_ra, ftr_wa, ftr_ra, nxt_wa, nxt_ra, prv_wa, prv_ra;
    logic [13:0]       hdr_wd;
    logic [GRAN_W-1:0] ftr_wd, nxt_wd, prv_wd;

    logic              r_kind, r_req_zero, r_free_bad;
    logic [GRAN_W-1:0] r_need, r_g, r_cur, r_found, r_have, r_size, r_start;
    logic [GRAN_W-1:0] r_head, r_top, r_n, r_p, r_nsize, r_psize, r_rm;
    logic              r_has_p, r_nfree, r_pfree;
    logic [IDX_W-1:0]  r_clr;
    t_out_item         r_res;

    logic [16:0]       need_sum;
    logic [GRAN_W-1:0] need_raw, need_in, g_in;
    logic [15:0]       addr_off;
    logic [GRAN_W-1:0] hdr_size, ps, pp, nn, mg_n;
    logic [GRAN_W:0]   top_sum;
    logic              top_fail, split, has_p;

    always_comb begin
        need_sum = {1'b0, i_item.request_bytes} + 17'd23;
        need_raw = need_sum[16:4];
        need_in = (need_raw < MIN_GRANULES) ? MIN_GRANULES : need_raw;
        addr_off = i_item.free_address - 16'd8;
        g_in = {1'b0, addr_off[15:4]};
        hdr_size = r_hdr_q[13:1];
        top_sum = {1'b0, r_top} + {1'b0, r_need};
        top_fail = top_sum > (GRAN_W + 1)'(HEAP_GRANULES);
        split = {1'b0, r_have} >= ({1'b0, r_need} + {1'b0, MIN_GRANULES});
        ps = (r_g == '0) ? '0 : r_ftr_q;
        has_p = (ps != '0) && (ps <= r_g);
        pp = r_prv_q;
        nn = r_nxt_q;
        mg_n = r_g + r_size;
    end

    // Memory port steering per sequencer step.
    always_comb begin
        hdr_we = 1'b0; hdr_wa = '0; hdr_wd = '0; hdr_re = 1'b0; hdr_ra = '0;
        ftr_we = 1'b0; ftr_wa = '0; ftr_wd = '0; ftr_re = 1'b0; ftr_ra = '0;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_re = 1'b0; nxt_ra = '0;
        prv_we = 1'b0; prv_wa = '0; prv_wd = '0; prv_re = 1'b0; prv_ra = '0;
        case (i_cmd.step)
            S_CLEAR: begin
                hdr_we = 1'b1; hdr_wa = r_clr;
                ftr_we = 1'b1; ftr_wa = r_clr;
            end
            S_DISP: begin
                hdr_re = 1'b1; hdr_ra = r_g[IDX_W-1:0];
            end
            S_WALK: begin
                hdr_re = (r_cur != NONE_MARK); hdr_ra = r_cur[IDX_W-1:0];
                nxt_re = (r_cur != NONE_MARK); nxt_ra = r_cur[IDX_W-1:0];
            end
            S_TOP: begin
                hdr_we = !top_fail; hdr_wa = r_top[IDX_W-1:0]; hdr_wd = {r_need, 1'b1};
                ftr_we = !top_fail;
                ftr_wa = IDX_W'(r_top + r_need - 1'b1);
                ftr_wd = r_need;
            end
            S_RM_RD: begin
                prv_re = 1'b1; prv_ra = r_rm[IDX_W-1:0];
                nxt_re = 1'b1; nxt_ra = r_rm[IDX_W-1:0];
            end
            S_RM_WR: begin
                nxt_we = (pp < NONE_MARK); nxt_wa = pp[IDX_W-1:0]; nxt_wd = nn;
                prv_we = (nn < NONE_MARK); prv_wa = nn[IDX_W-1:0]; prv_wd = pp;
            end
            S_SPLIT: begin
                hdr_we = 1'b1;
                ftr_we = 1'b1;
                ftr_wa = IDX_W'(r_found + r_have - 1'b1);
                if (split) begin
                    hdr_wa = IDX_W'(r_found + r_need);
                    hdr_wd = {r_have - r_need, 1'b0};
                    ftr_wd = r_have - r_need;
                end else begin
                    hdr_wa = r_found[IDX_W-1:0];
                    hdr_wd = {r_have, 1'b1};
                    ftr_wd = r_have;
                end
            end
            S_SPL2: begin
                hdr_we = 1'b1; hdr_wa = r_found[IDX_W-1:0]; hdr_wd = {r_need, 1'b1};
                ftr_we = 1'b1;
                ftr_wa = IDX_W'(r_found + r_need - 1'b1);
                ftr_wd = r_need;
            end
            S_F_HD: begin
                hdr_we = r_hdr_q[0]; hdr_wa = r_g[IDX_W-1:0]; hdr_wd = {hdr_size, 1'b0};
                ftr_we = r_hdr_q[0] && (hdr_size != '0);
                ftr_wa = IDX_W'(r_g + hdr_size - 1'b1);
                ftr_wd = hdr_size;
            end
            S_MG_RD: begin
                ftr_re = 1'b1; ftr_ra = IDX_W'(r_g - 1'b1);
                hdr_re = 1'b1; hdr_ra = mg_n[IDX_W-1:0];
            end
            S_MG_P: begin
                hdr_re = 1'b1; hdr_ra = IDX_W'(r_g - ps);
            end
            S_MG_SET: begin
                hdr_we = 1'b1; hdr_wa = r_start[IDX_W-1:0]; hdr_wd = {r_size, 1'b0};
                ftr_we = 1'b1;
                ftr_wa = IDX_W'(r_start + r_size - 1'b1);
                ftr_wd = r_size;
            end
            S_PS1: begin
                nxt_we = 1'b1; nxt_wa = r_start[IDX_W-1:0]; nxt_wd = r_head;
                prv_we = 1'b1; prv_wa = r_start[IDX_W-1:0]; prv_wd = NONE_MARK;
            end
            S_PS2: begin
                prv_we = (r_head != NONE_MARK); prv_wa = r_head[IDX_W-1:0];
                prv_wd = r_start;
            end
            default: begin
                hdr_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hdr_we) r_hdr_mem[hdr_wa] <= hdr_wd;
        if (hdr_re) r_hdr_q <= r_hdr_mem[hdr_ra];
        if (ftr_we) r_ftr_mem[ftr_wa] <= ftr_wd;
        if (ftr_re) r_ftr_q <= r_ftr_mem[ftr_ra];
        if (nxt_we) r_nxt_mem[nxt_wa] <= nxt_wd;
        if (nxt_re) r_nxt_q <= r_nxt_mem[nxt_ra];
        if (prv_we) r_prv_mem[prv_wa] <= prv_wd;
        if (prv_re) r_prv_q <= r_prv_mem[prv_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= NONE_MARK;
            r_top <= '0;
            r_clr <= '0;
        end else begin
            case (i_cmd.step)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_RM_WR: begin
                    if (!(pp < NONE_MARK)) r_head <= nn;
                end
                S_TOP: begin
                    if (!top_fail) r_top <= r_top + r_need;
                end
                S_PS2: r_head <= r_start;
                default: r_clr <= r_clr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_item.kind;
            r_req_zero <= (i_item.request_bytes == 16'd0);
            r_need <= need_in;
            r_g <= g_in;
            r_free_bad <= (i_item.free_address[3:0] != 4'h8) || (g_in >= r_top);
            r_cur <= r_head;
        end
        case (i_cmd.step)
            S_DISP: begin
                if (r_kind == KIND_ALLOC) begin
                    r_res <= '{address: 16'd0, status: ST_ALLOC_FAIL, merged_granules: '0};
                end else begin
                    r_res <= '{address: 16'd0, status: ST_FREE_BAD, merged_granules: '0};
                end
            end
            S_WALK_W: begin
                if (hdr_size >= r_need) begin
                    r_found <= r_cur;
                    r_have <= hdr_size;
                    r_rm <= r_cur;
                end else begin
                    r_cur <= r_nxt_q;
                end
            end
            S_TOP: begin
                if (!top_fail) begin
                    r_res <= '{address: {r_top[IDX_W-1:0], 4'h8}, status: ST_DONE,
                               merged_granules: '0};
                end
            end
            S_SPLIT: begin
                r_g <= r_found + r_need;
                r_size <= r_have - r_need;
                r_res <= '{address: {r_found[IDX_W-1:0], 4'h8}, status: ST_DONE,
                           merged_granules: '0};
            end
            S_F_HD: r_size <= hdr_size;
            S_MG_RD: r_n <= mg_n;
            S_MG_P: begin
                r_has_p <= has_p;
                r_p <= r_g - ps;
                r_nfree <= (r_n < r_top) && !r_hdr_q[0];
                r_nsize <= hdr_size;
            end
            S_MG_PW: begin
                r_pfree <= r_has_p && !r_hdr_q[0];
                r_psize <= hdr_size;
                r_rm <= r_n;
            end
            S_MG_SUM: begin
                r_size <= r_size + (r_nfree ? r_nsize : '0) + (r_pfree ? r_psize : '0);
                r_start <= r_pfree ? r_p : r_g;
                r_rm <= r_p;
            end
            S_PS2: begin
                if (r_kind == KIND_FREE) begin
                    r_res <= '{address: 16'd0, status: ST_DONE, merged_granules: r_size};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.kind = r_kind;
    assign o_stat.req_zero = r_req_zero;
    assign o_stat.free_bad = r_free_bad;
    assign o_stat.cur_none = (r_cur == NONE_MARK);
    assign o_stat.fit = (hdr_size >= r_need);
    assign o_stat.split = split;
    assign o_stat.hdr_inuse = r_hdr_q[0];
    assign o_stat.nfree = r_nfree;
    assign o_stat.pfree = r_pfree;
    assign o_stat.clr_last = (r_clr == '1);
    assign o_result = r_res;

endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// First-fit heap allocator over 4096 granules of 16 bytes.
// A request beat is taken on a rising edge with start high and busy low:
// kind 0 allocates request_bytes, kind 1 frees the block at free_address.
// Each request gives exactly one result beat on o_result, flagged by
// o_done for one cycle; the receiver must take it then, as it cannot stall.
// A zero request or an invalid free ends without changing the heap. An
// allocation walks the free list block by block for the first fit; with
// none it grows the heap top, else it takes the whole block or splits it
// and merges the remainder with its free neighbors. A valid free merges
// the block with whichever neighbors are free. Each header, footer and link
// memory has one read and one write port; one request is handled at a
// time, and busy stays high through the o_done cycle.
// After reset the header and footer memories are swept to zero, one entry
// per cycle; busy is high during the sweep. The free list and heap top
// come out of reset empty.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_cmd,
    output logic      busy,
    output logic      o_done,
    output t_out_item o_result
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    ffha_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_cmd),
        .o_stat   (dp_stat),
        .o_result (o_result)
    );

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted request did not start work");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == ST_DONE || o_result.status == ST_ALLOC_FAIL ||
                    o_result.status == ST_FREE_BAD))
        else $error("undefined status code on result");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ffha_pkg::*;

    localparam int NG = HEAP_GRANULES;
    localparam int NO_BLOCK = HEAP_GRANULES;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  i_cmd = '0;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    first_fit_heap_allocator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // Shadow heap: headers hold size << 1 | in-use, footers the size of the block ending there.
    int unsigned hdr_mem[NG];
    int unsigned ftr_mem[NG];
    int unsigned nxt_mem[NG];
    int unsigned prv_mem[NG];
    int unsigned free_head = NO_BLOCK;
    int unsigned top_gran = 0;

    t_out_item   pending_q[$];
    int unsigned live_q[$];
    int unsigned freed_q[$];
    int          err_cnt = 0;
    bit          no_gaps = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic int unsigned blk_granules(int unsigned g);
        return (g < NO_BLOCK) ? (hdr_mem[g] >> 1) : 0;
    endfunction

    function automatic bit blk_busy(int unsigned g);
        return (g < NO_BLOCK) ? hdr_mem[g][0] : 1'b1;
    endfunction

    function automatic void mark_blk(int unsigned g, int unsigned sz, bit used);
        if (g < NO_BLOCK) hdr_mem[g] = (sz << 1) | used;
        if (sz != 0 && g + sz - 1 < NO_BLOCK) ftr_mem[g + sz - 1] = sz;
    endfunction

    function automatic void unlink(int unsigned b);
        int unsigned p;
        int unsigned n;
        if (b >= NO_BLOCK) return;
        p = prv_mem[b];
        n = nxt_mem[b];
        if (p < NO_BLOCK) nxt_mem[p] = n;
        else free_head = n;
        if (n < NO_BLOCK) prv_mem[n] = p;
    endfunction

    function automatic void link_front(int unsigned b);
        if (b >= NO_BLOCK) return;
        nxt_mem[b] = free_head;
        prv_mem[b] = NO_BLOCK;
        if (free_head < NO_BLOCK) prv_mem[free_head] = b;
        free_head = b;
    endfunction

    function automatic int unsigned coalesce(int unsigned g, output int unsigned sz);
        int unsigned ps;
        int unsigned p;
        int unsigned n;
        bit          has_p;
        bit          pfree;
        bit          nfree;
        int unsigned first;
        sz = blk_granules(g);
        ps = (g > 0 && g < NO_BLOCK) ? ftr_mem[g - 1] : 0;
        has_p = ps != 0 && ps <= g;
        p = has_p ? g - ps : 0;
        n = g + sz;
        pfree = has_p && !blk_busy(p);
        nfree = n < top_gran && !blk_busy(n);
        first = g;
        if (nfree) begin
            unlink(n);
            sz += blk_granules(n);
        end
        if (pfree) begin
            unlink(p);
            sz += blk_granules(p);
            first = p;
        end
        mark_blk(first, sz, 1'b0);
        return first;
    endfunction

    function automatic t_out_item heap_predict(t_in_item it);
        t_out_item   r;
        int unsigned req;
        int unsigned adr;
        int unsigned need;
        int unsigned cur;
        int unsigned hops;
        int unsigned hit;
        int unsigned have;
        int unsigned msz;
        int unsigned g;
        r = '0;
        r.status = ST_DONE;
        req = it.request_bytes;
        adr = it.free_address;
        if (it.kind == KIND_ALLOC) begin
            need = (req + 23) >> 4;
            if (need < 2) need = 2;
            cur = free_head;
            hops = 0;
            hit = NO_BLOCK;
            if (req == 0) begin
                r.status = ST_ALLOC_FAIL;
            end else begin
                while (cur < NO_BLOCK && hops < NG) begin
                    if (blk_granules(cur) >= need) begin
                        hit = cur;
                        break;
                    end
                    cur = nxt_mem[cur];
                    hops++;
                end
                if (hit < NO_BLOCK) begin
                    have = blk_granules(hit);
                    unlink(hit);
                    if (have >= need + 2) begin
                        mark_blk(hit + need, have - need, 1'b0);
                        mark_blk(hit, need, 1'b1);
                        link_front(coalesce(hit + need, msz));
                    end else begin
                        mark_blk(hit, have, 1'b1);
                    end
                    r.address = 16'(hit * 16 + 8);
                end else if (top_gran + need > NG) begin
                    r.status = ST_ALLOC_FAIL;
                end else begin
                    mark_blk(top_gran, need, 1'b1);
                    r.address = 16'(top_gran * 16 + 8);
                    top_gran += need;
                end
            end
        end else begin
            g = (adr - 8) >> 4;
            if (adr < 8 || ((adr - 8) & 15) != 0 || g >= top_gran || !blk_busy(g)) begin
                r.status = ST_FREE_BAD;
            end else begin
                mark_blk(g, blk_granules(g), 1'b0);
                link_front(coalesce(g, msz));
                r.merged_granules = 13'(msz);
            end
        end
        return r;
    endfunction

    // Busy only moves at rising edges, so its value at the falling edge is the one the
    // next rising edge sees.
    task automatic send_beat(t_in_item it, output t_out_item exp);
        int  gap;
        logic b;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= it;
        do begin
            @(negedge i_clk);
            b = busy;
            @(posedge i_clk);
        end while (b);
        exp = heap_predict(it);
        pending_q.push_back(exp);
    endtask

    task automatic do_alloc(int unsigned req);
        t_in_item  it;
        t_out_item exp;
        it.kind = KIND_ALLOC;
        it.request_bytes = 16'(req);
        it.free_address = 16'($urandom);
        send_beat(it, exp);
        if (exp.status == ST_DONE) live_q.push_back(exp.address);
    endtask

    task automatic do_free(int unsigned adr);
        t_in_item  it;
        t_out_item exp;
        it.kind = KIND_FREE;
        it.request_bytes = 16'($urandom);
        it.free_address = 16'(adr);
        send_beat(it, exp);
        if (exp.status == ST_DONE) begin
            foreach (live_q[i]) begin
                if (live_q[i] == adr) begin
                    live_q.delete(i);
                    break;
                end
            end
            freed_q.push_back(adr);
        end
    endtask

    function automatic int unsigned pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 120);
        if (roll < 96) return $urandom_range(121, 2000);
        return $urandom_range(0, 65535);
    endfunction

    task automatic free_random_live();
        int unsigned k;
        k = $urandom_range(0, live_q.size() - 1);
        do_free(live_q[k]);
    endtask

    task automatic test_directed();
        do_alloc(0);
        do_alloc(1);
        do_alloc(8);
        do_alloc(9);
        do_alloc(65535);
        do_free(0);
        do_free(7);
        do_free(9);
        do_free(65535);
        do_free(40);
        do_free(40);
        do_free(8);
        do_free(72);
        do_alloc(100);
        do_free(8);
        do_alloc(20);
        do_alloc(40);
        do_alloc(17);
        do_alloc(24);
        do_alloc(25);
        while (live_q.size() > 0) free_random_live();
    endtask

    task automatic test_churn(int n);
        int unsigned k;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, 99);
            if (live_q.size() == 0 || k < 52) begin
                do_alloc(pick_size());
            end else if (k < 88) begin
                free_random_live();
            end else if (k < 94 && freed_q.size() > 0) begin
                do_free(freed_q[$urandom_range(0, freed_q.size() - 1)]);
            end else begin
                do_free($urandom_range(0, 65535));
            end
        end
    endtask

    // Large requests run the heap top into the end of the heap.
    task automatic test_fill();
        for (int i = 0; i < 30; i++) do_alloc($urandom_range(4000, 16000));
        do_alloc(65535);
        do_alloc(65000);
        repeat (live_q.size() / 2) free_random_live();
        do_alloc(65535);
    endtask

    task automatic test_drain();
        while (live_q.size() > 0) free_random_live();
        do_alloc(64000);
    endtask

    always @(negedge i_clk) begin
        t_out_item exp;
        if (i_rst_n && o_done) begin
            if (pending_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected result beat %p", o_result);
            end else begin
                exp = pending_q.pop_front();
                if (o_result.address !== exp.address || o_result.status !== exp.status
                        || o_result.merged_granules !== exp.merged_granules) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch: expected addr %0d st %0d merged %0d, got %0d %0d %0d",
                            exp.address, exp.status, exp.merged_granules,
                            o_result.address, o_result.status, o_result.merged_granules);
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_churn(850);
        test_fill();
        test_churn(900);
        test_drain();
        start <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ffha_pkg.sv
rtl/core/ffha_ctrl.sv
rtl/core/ffha_dp.sv
rtl/core/first_fit_heap_allocator.sv
test/tb_top.sv
